/* rtl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic real-root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int ROOT_WIDTH = 32;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_TWO    = 2'd2,
        KIND_DEGEN  = 2'd3
    } root_kind_t;

endpackage

/* rtl/qrs_if.sv */
// ----------------------------------------------------------------------------
// qrs_if
// Valid/ready channels for coefficient items and for root results.
// ----------------------------------------------------------------------------
interface qrs_coef_if
    import qrs_pkg::*;
#(
    parameter int CW = COEF_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if
    import qrs_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   root_kind;
    logic signed [ROOT_WIDTH-1:0] root_low;
    logic signed [ROOT_WIDTH-1:0] root_high;

    modport source (output valid, root_kind, root_low, root_high, input ready);
    modport sink   (input valid, root_kind, root_low, root_high, output ready);
endinterface

/* rtl/quadratic_root_solver_top.sv */
// Throughput: one item per cycle while the output is not stalled; the square root takes one stage per result bit and
// each divider one stage per quotient bit, so every stage holds its own item.
// A stall at the output holds the whole pipeline in place, nothing is lost.
// Reset clears all valid bits; no result is pending afterwards.
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c in signed fixed point.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top
    import qrs_pkg::*;
#(
    parameter int FRAC_W = FRAC_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    qrs_coef_if.sink   coef_in,
    qrs_root_if.source root_out
);
    // The coefficient width is fixed by the channel, so it comes from the package.
    localparam int CW  = COEF_WIDTH;
    localparam int FB  = FRAC_W;
    localparam int DW  = 2 * CW + 1;
    localparam int SQW = (DW + 1) / 2 + FB;
    localparam int NW  = CW + FB + 2;
    localparam int MW  = CW + 1;
    localparam int RW  = ROOT_WIDTH;
    localparam int SW  = (NW + 1 > RW) ? NW + 1 : RW;
    localparam int STW = 2 + 2 * CW;

    localparam logic signed [SW-1:0] RMAX = SW'(32'sh7fffffff);
    localparam logic signed [SW-1:0] RMIN = SW'(32'sh80000000);

    logic en;

    // Discriminant stages.
    logic                 d_valid;
    logic signed [CW-1:0] d_a, d_b;
    root_kind_t           d_kind;
    logic [DW-1:0]        d_mag;

    // Square root stages.
    logic                 s_valid;
    logic [SQW-1:0]       s_root;
    logic [STW-1:0]       s_tag;
    root_kind_t           s_kind;
    logic signed [CW-1:0] s_a, s_b;

    // Numerator and divisor stage.
    logic                 p_valid_reg;
    logic [NW-1:0]        p_lo_reg, p_hi_reg;
    logic [MW-1:0]        p_den_reg;
    logic                 p_lo_neg_reg, p_hi_neg_reg;
    logic [2:0]           p_tag_reg;
    logic                 p_aneg_reg;
    logic signed [NW:0]   b_ext, nb, num_lo, num_hi, s_ext;
    logic signed [MW:0]   a_ext, two_a;
    logic [NW-1:0]        lo_mag, hi_mag;
    logic [MW-1:0]        den_mag;

    // Divider outputs.
    logic                 q_valid, q_hi_valid;
    logic [NW-1:0]        q_lo, q_hi;
    logic                 q_lo_neg, q_hi_neg;
    logic [2:0]           q_tag;
    logic                 q_aneg;

    // Output stage.
    logic                 o_valid_reg;
    logic [1:0]           o_kind_reg;
    logic signed [RW-1:0] o_low_reg, o_high_reg;
    logic signed [NW:0]   r_lo, r_hi;
    logic signed [SW-1:0] w_lo, w_hi;
    logic signed [RW-1:0] sat_lo, sat_hi;
    logic [1:0]           o_kind_next;
    logic signed [RW-1:0] o_low_next, o_high_next;

    assign en            = !o_valid_reg || root_out.ready;
    assign coef_in.ready = en;

    qrs_disc #(.CW(CW)) u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coef_in.valid),
        .a         (coef_in.coef_a),
        .b         (coef_in.coef_b),
        .c         (coef_in.coef_c),
        .out_valid (d_valid),
        .out_a     (d_a),
        .out_b     (d_b),
        .kind      (d_kind),
        .disc_mag  (d_mag)
    );

    qrs_sqrt #(.IN_W(DW), .FB(FB), .TAG_W(STW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .radicand  (d_mag),
        .in_tag    ({d_kind, d_a, d_b}),
        .out_valid (s_valid),
        .root      (s_root),
        .out_tag   (s_tag)
    );

    assign s_kind = root_kind_t'(s_tag[STW-1 -: 2]);
    assign s_a    = s_tag[2*CW-1 -: CW];
    assign s_b    = s_tag[CW-1:0];

    always_comb
    begin
        b_ext   = {{(NW+1-CW){s_b[CW-1]}}, s_b};
        nb      = (-b_ext) <<< FB;
        s_ext   = {{(NW+1-SQW){1'b0}}, s_root};
        num_lo  = nb - s_ext;
        num_hi  = nb + s_ext;
        lo_mag  = num_lo[NW] ? NW'(-num_lo) : num_lo[NW-1:0];
        hi_mag  = num_hi[NW] ? NW'(-num_hi) : num_hi[NW-1:0];
        a_ext   = {{(MW+1-CW){s_a[CW-1]}}, s_a};
        two_a   = a_ext <<< 1;
        den_mag = s_a[CW-1] ? MW'(-two_a) : two_a[MW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg     <= lo_mag;
            p_hi_reg     <= hi_mag;
            p_den_reg    <= den_mag;
            p_lo_neg_reg <= num_lo[NW] ^ s_a[CW-1];
            p_hi_neg_reg <= num_hi[NW] ^ s_a[CW-1];
            p_tag_reg    <= {s_kind, s_a[CW-1]};
            p_aneg_reg   <= s_a[CW-1];
        end
    end

    qrs_div #(.NW(NW), .MW(MW), .TAG_W(3)) u_div_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid_reg),
        .num       (p_lo_reg),
        .den       (p_den_reg),
        .in_neg    (p_lo_neg_reg),
        .in_tag    (p_tag_reg),
        .out_valid (q_valid),
        .quot      (q_lo),
        .out_neg   (q_lo_neg),
        .out_tag   (q_tag)
    );

    qrs_div #(.NW(NW), .MW(MW), .TAG_W(1)) u_div_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid_reg),
        .num       (p_hi_reg),
        .den       (p_den_reg),
        .in_neg    (p_hi_neg_reg),
        .in_tag    (p_aneg_reg),
        .out_valid (q_hi_valid),
        .quot      (q_hi),
        .out_neg   (q_hi_neg),
        .out_tag   (q_aneg)
    );

    // With a positive divisor the root taken with -sqrt(D) is the smaller one.
    always_comb
    begin
        r_lo   = q_lo_neg ? -$signed({1'b0, q_lo}) : $signed({1'b0, q_lo});
        r_hi   = q_hi_neg ? -$signed({1'b0, q_hi}) : $signed({1'b0, q_hi});
        w_lo   = SW'(r_lo);
        w_hi   = SW'(r_hi);
        sat_lo = (w_lo > RMAX) ? RW'(RMAX) : ((w_lo < RMIN) ? RW'(RMIN) : RW'(w_lo));
        sat_hi = (w_hi > RMAX) ? RW'(RMAX) : ((w_hi < RMIN) ? RW'(RMIN) : RW'(w_hi));
        o_kind_next = q_tag[2:1];
        case (root_kind_t'(q_tag[2:1])) inside
            KIND_DOUBLE, KIND_TWO:
            begin
                o_low_next  = q_aneg ? sat_hi : sat_lo;
                o_high_next = q_aneg ? sat_lo : sat_hi;
            end
            default:
            begin
                o_low_next  = '0;
                o_high_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= q_valid && q_hi_valid && (q_tag[0] == q_aneg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_kind_reg <= o_kind_next;
            o_low_reg  <= o_low_next;
            o_high_reg <= o_high_next;
        end
    end

    assign root_out.valid     = o_valid_reg;
    assign root_out.root_kind = o_kind_reg;
    assign root_out.root_low  = o_low_reg;
    assign root_out.root_high = o_high_reg;
endmodule

/* rtl/qrs_disc.sv */
// ----------------------------------------------------------------------------
// qrs_disc
// Two stages: the products b*b and a*c, then the discriminant and the case.
// ----------------------------------------------------------------------------
module qrs_disc
    import qrs_pkg::*;
#(
    parameter int CW = COEF_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] a,
    input  logic signed [CW-1:0] b,
    input  logic signed [CW-1:0] c,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_a,
    output logic signed [CW-1:0] out_b,
    output root_kind_t           kind,
    output logic [2*CW:0]        disc_mag
);
    localparam int PW = 2 * CW;
    localparam int DSW = 2 * CW + 3;

    logic                 v1_reg, v2_reg;
    logic signed [CW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [PW-1:0] bb_reg, ac_reg;
    logic signed [DSW-1:0] disc;
    root_kind_t           kind_next, kind_reg;
    logic [PW:0]          mag_next, mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= a;
            b1_reg   <= b;
            bb_reg   <= b * b;
            ac_reg   <= a * c;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            kind_reg <= kind_next;
            mag_reg  <= mag_next;
        end
    end

    always_comb
    begin
        disc = $signed({{3{bb_reg[PW-1]}}, bb_reg})
             - $signed({ac_reg[PW-1], ac_reg, 2'b00});
        mag_next = '0;
        if (a1_reg == '0)
            kind_next = KIND_DEGEN;
        else if (disc[DSW-1])
            kind_next = KIND_NONE;
        else if (disc == '0)
            kind_next = KIND_DOUBLE;
        else
        begin
            kind_next = KIND_TWO;
            mag_next  = disc[PW:0];
        end
    end

    assign out_valid = v2_reg;
    assign out_a     = a2_reg;
    assign out_b     = b2_reg;
    assign kind      = kind_reg;
    assign disc_mag  = mag_reg;
endmodule

/* rtl/qrs_sqrt.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt
// Restoring square root, one result bit per pipeline stage; gives
// floor(sqrt(d) * 2^FB) and carries a tag alongside.
// ----------------------------------------------------------------------------
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int IN_W  = 2 * COEF_WIDTH + 1,
    parameter int FB    = FRAC_BITS,
    parameter int TAG_W = 1
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [IN_W-1:0]                     radicand,
    input  logic [TAG_W-1:0]                    in_tag,
    output logic                                out_valid,
    output logic [(IN_W+1)/2+FB-1:0]            root,
    output logic [TAG_W-1:0]                    out_tag
);
    localparam int N   = (IN_W + 1) / 2 + FB;
    localparam int XW  = 2 * N;
    localparam int RW  = N + 3;
    localparam int PAD = XW - IN_W - 2 * FB;

    logic             vld_reg  [N];
    logic [XW-1:0]    x_reg    [N];
    logic [RW-1:0]    rem_reg  [N];
    logic [N-1:0]     root_reg [N];
    logic [TAG_W-1:0] tag_reg  [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic             cur_v;
        logic [XW-1:0]    cur_x;
        logic [RW-1:0]    cur_rem;
        logic [N-1:0]     cur_root;
        logic [TAG_W-1:0] cur_tag;
        logic [RW-1:0]    rem_sh, trial;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign cur_v    = in_valid;
            assign cur_x    = {{PAD{1'b0}}, radicand, {(2*FB){1'b0}}};
            assign cur_rem  = '0;
            assign cur_root = '0;
            assign cur_tag  = in_tag;
        end
        else
        begin : g_next
            assign cur_v    = vld_reg[i-1];
            assign cur_x    = x_reg[i-1];
            assign cur_rem  = rem_reg[i-1];
            assign cur_root = root_reg[i-1];
            assign cur_tag  = tag_reg[i-1];
        end

        always_comb
        begin
            rem_sh = {cur_rem[RW-3:0], cur_x[XW-1 -: 2]};
            trial  = {1'b0, cur_root, 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= cur_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= cur_x << 2;
                rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {cur_root[N-2:0], ge};
                tag_reg[i]  <= cur_tag;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_tag   = tag_reg[N-1];
endmodule

/* rtl/qrs_div.sv */
// ----------------------------------------------------------------------------
// qrs_div
// Restoring unsigned divider, one quotient bit per pipeline stage; the sign
// request and a tag travel with the item.
// ----------------------------------------------------------------------------
module qrs_div
    import qrs_pkg::*;
#(
    parameter int NW    = 2 * COEF_WIDTH,
    parameter int MW    = COEF_WIDTH + 1,
    parameter int TAG_W = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NW-1:0]    num,
    input  logic [MW-1:0]    den,
    input  logic             in_neg,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NW-1:0]    quot,
    output logic             out_neg,
    output logic [TAG_W-1:0] out_tag
);
    logic             vld_reg [NW];
    logic [NW-1:0]    n_reg   [NW];
    logic [MW-1:0]    r_reg   [NW];
    logic [NW-1:0]    q_reg   [NW];
    logic [MW-1:0]    d_reg   [NW];
    logic             neg_reg [NW];
    logic [TAG_W-1:0] tag_reg [NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic             cur_v, cur_neg, ge;
        logic [NW-1:0]    cur_n, cur_q;
        logic [MW-1:0]    cur_r, cur_d;
        logic [TAG_W-1:0] cur_tag;
        logic [MW:0]      r_sh, r_sub;

        if (i == 0)
        begin : g_first
            assign cur_v   = in_valid;
            assign cur_n   = num;
            assign cur_r   = '0;
            assign cur_q   = '0;
            assign cur_d   = den;
            assign cur_neg = in_neg;
            assign cur_tag = in_tag;
        end
        else
        begin : g_next
            assign cur_v   = vld_reg[i-1];
            assign cur_n   = n_reg[i-1];
            assign cur_r   = r_reg[i-1];
            assign cur_q   = q_reg[i-1];
            assign cur_d   = d_reg[i-1];
            assign cur_neg = neg_reg[i-1];
            assign cur_tag = tag_reg[i-1];
        end

        always_comb
        begin
            r_sh  = {cur_r, cur_n[NW-1]};
            r_sub = r_sh - {1'b0, cur_d};
            ge    = (r_sh >= {1'b0, cur_d});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= cur_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i]   <= cur_n << 1;
                r_reg[i]   <= ge ? r_sub[MW-1:0] : r_sh[MW-1:0];
                q_reg[i]   <= {cur_q[NW-2:0], ge};
                d_reg[i]   <= cur_d;
                neg_reg[i] <= cur_neg;
                tag_reg[i] <= cur_tag;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quot      = q_reg[NW-1];
    assign out_neg   = neg_reg[NW-1];
    assign out_tag   = tag_reg[NW-1];
endmodule
